>>> rtl/flow_state_table_macros.svh
// assertion macros for the flow state table
`ifndef FLOW_STATE_TABLE_MACROS_SVH
`define FLOW_STATE_TABLE_MACROS_SVH

// condition implies consequence in the same cycle
`define FST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define FST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fst_pkg.sv
// ----------------------------------------------------------------------------
// fst_pkg
// shared types and constants of the flow state table
// ----------------------------------------------------------------------------
package fst_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int MAX_KEY_WORDS_DEF = 4;

    localparam int KEY_W   = 64;
    localparam int WORDS_W = 3;
    localparam int STATE_W = 32;
    // valid, key low, key high, key words, state
    localparam int ENTRY_W = 1 + 2 * KEY_W + WORDS_W + STATE_W;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_SET    = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_WRITE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clear_wr;
        logic start;
        logic rd_en;
        logic cmp_en;
        logic commit;
    } t_ctl_cmd;

    localparam logic [1:0] REG_DEFAULT_STATE = 2'd0;

endpackage

>>> rtl/fst_ram.sv
// ----------------------------------------------------------------------------
// fst_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module fst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/fst_ctrl.sv
// ----------------------------------------------------------------------------
// fst_ctrl
// sequencer: clearing pass, table scan, commit and result handshake
// ----------------------------------------------------------------------------
module fst_ctrl #(
    parameter int TABLE_ENTRIES = fst_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             i_ready,
    output logic                             o_ready,
    output logic                             o_valid,
    output fst_pkg::t_ctl_cmd                o_cmd,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_addr,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_cmp_addr
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

    fst_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic            r_cmp;
    logic [AW-1:0]   r_cmp_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fst_pkg::ST_CLEAR;
            r_cnt      <= '0;
            r_cmp      <= 1'b0;
            r_cmp_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_cmp      <= (r_state == fst_pkg::ST_SCAN);
            r_cmp_addr <= r_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            fst_pkg::ST_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_state = fst_pkg::ST_IDLE;
                    n_cnt   = '0;
                end
            end
            fst_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (i_valid) begin
                    n_state = fst_pkg::ST_SCAN;
                end
            end
            fst_pkg::ST_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_state = fst_pkg::ST_TAIL;
                    n_cnt   = '0;
                end
            end
            fst_pkg::ST_TAIL:  n_state = fst_pkg::ST_WRITE;
            fst_pkg::ST_WRITE: n_state = fst_pkg::ST_OUT;
            fst_pkg::ST_OUT: begin
                if (i_ready) begin
                    n_state = fst_pkg::ST_IDLE;
                end
            end
            default: n_state = fst_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_ready        = 1'b0;
        o_valid        = 1'b0;
        o_cmd.cmp_en   = r_cmp;
        unique case (r_state)
            fst_pkg::ST_CLEAR: o_cmd.clear_wr = 1'b1;
            fst_pkg::ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.start  = i_valid;
            end
            fst_pkg::ST_SCAN:  o_cmd.rd_en  = 1'b1;
            fst_pkg::ST_TAIL:  o_cmd.rd_en  = 1'b0;
            fst_pkg::ST_WRITE: o_cmd.commit = 1'b1;
            fst_pkg::ST_OUT:   o_valid      = 1'b1;
            default:           o_ready      = 1'b0;
        endcase
    end

    assign o_addr     = r_cnt;
    assign o_cmp_addr = r_cmp_addr;

endmodule

>>> rtl/fst_datapath.sv
// ----------------------------------------------------------------------------
// fst_datapath
// request latch, entry ram, key compare, match and free tracking, result
// ----------------------------------------------------------------------------
module fst_datapath #(
    parameter int TABLE_ENTRIES = fst_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_KEY_WORDS = fst_pkg::MAX_KEY_WORDS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fst_pkg::t_ctl_cmd                   i_cmd,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]    i_addr,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]    i_cmp_addr,
    input  logic [fst_pkg::STATE_W-1:0]         i_default_state,
    input  logic [1:0]                          i_command,
    input  logic [fst_pkg::KEY_W-1:0]           i_key_low,
    input  logic [fst_pkg::KEY_W-1:0]           i_key_high,
    input  logic [fst_pkg::WORDS_W-1:0]         i_key_words,
    input  logic [fst_pkg::STATE_W-1:0]         i_new_state,
    output logic [fst_pkg::STATE_W-1:0]         o_state_value,
    output logic                                o_hit,
    output logic                                o_status
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int KW = fst_pkg::KEY_W;
    localparam int NW = fst_pkg::WORDS_W;
    localparam int SW = fst_pkg::STATE_W;
    localparam int EW = fst_pkg::ENTRY_W;
    localparam logic [NW-1:0] MAXW = NW'(MAX_KEY_WORDS);

    fst_pkg::t_cmd r_command;
    logic [KW-1:0] r_lo, r_hi;
    logic [NW-1:0] r_n;
    logic [SW-1:0] r_ns;
    logic          r_hit, r_free;
    logic [AW-1:0] r_hit_idx, r_free_idx;
    logic [SW-1:0] r_hit_state;
    logic [SW-1:0] r_state_value;
    logic          r_hit_out, r_status;

    logic [NW-1:0] n_words;
    logic [KW-1:0] m_lo, m_hi;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data, rd_data;
    logic          e_valid, e_match;
    logic [KW-1:0] e_lo, e_hi;
    logic [NW-1:0] e_n;
    logic [SW-1:0] e_state;

    // clamp key length and drop unused words
    always_comb begin
        n_words = i_key_words;
        if (i_key_words == '0) begin
            n_words = NW'(1);
        end else if (i_key_words > MAXW) begin
            n_words = MAXW;
        end
        m_lo = (n_words >= NW'(2)) ? i_key_low : {{(KW/2){1'b0}}, i_key_low[KW/2-1:0]};
        if (n_words >= NW'(4)) begin
            m_hi = i_key_high;
        end else if (n_words == NW'(3)) begin
            m_hi = {{(KW/2){1'b0}}, i_key_high[KW/2-1:0]};
        end else begin
            m_hi = '0;
        end
    end

    assign {e_valid, e_lo, e_hi, e_n, e_state} = rd_data;
    assign e_match = e_valid && (e_n == r_n) && (e_lo == r_lo) && (e_hi == r_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_cmd.start) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_cmd.cmp_en) begin
            if (e_match && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (!e_valid && !r_free) begin
                r_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_command <= fst_pkg::t_cmd'(i_command);
            r_lo      <= m_lo;
            r_hi      <= m_hi;
            r_n       <= n_words;
            r_ns      <= i_new_state;
        end
        if (i_cmd.cmp_en && e_match && !r_hit) begin
            r_hit_idx   <= i_cmp_addr;
            r_hit_state <= e_state;
        end
        if (i_cmd.cmp_en && !e_valid && !r_free) begin
            r_free_idx <= i_cmp_addr;
        end
    end

    // write port: clearing pass or commit
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = i_addr;
        wr_data = '0;
        if (i_cmd.clear_wr) begin
            wr_en = 1'b1;
        end else if (i_cmd.commit) begin
            case (r_command)
                fst_pkg::CMD_SET: begin
                    wr_en   = r_hit || r_free;
                    wr_addr = r_hit ? r_hit_idx : r_free_idx;
                    wr_data = {1'b1, r_lo, r_hi, r_n, r_ns};
                end
                fst_pkg::CMD_DELETE: begin
                    wr_en   = r_hit;
                    wr_addr = r_hit_idx;
                end
                default: wr_en = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_hit_out <= r_hit && (r_command != fst_pkg::CMD_NONE);
            case (r_command)
                fst_pkg::CMD_LOOKUP: begin
                    r_state_value <= r_hit ? r_hit_state : i_default_state;
                    r_status      <= 1'b0;
                end
                fst_pkg::CMD_SET: begin
                    r_state_value <= (r_hit || r_free) ? r_ns : '0;
                    r_status      <= !(r_hit || r_free);
                end
                default: begin
                    r_state_value <= '0;
                    r_status      <= 1'b0;
                end
            endcase
        end
    end

    fst_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_ENTRIES)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (i_cmd.rd_en),
        .i_rd_addr(i_addr),
        .o_rd_data(rd_data)
    );

    assign o_state_value = r_state_value;
    assign o_hit         = r_hit_out;
    assign o_status      = r_status;

endmodule

>>> rtl/flow_state_table.sv
// ----------------------------------------------------------------------------
// flow_state_table
// exact-match flow state table with lookup, set and delete requests
// ----------------------------------------------------------------------------
// input channel i_valid/o_ready carries one request: command, key of one to
// four 32-bit words, key length and new state. output channel o_valid/i_ready
// carries one result per request: state value, hit and full status.
// default_state is written over the apb port at byte address 0.
// each request scans every table entry through one ram read port, one entry
// per cycle, then commits in a single write; the result is shown after the
// commit, and the sequencer returns to idle only after the result is taken,
// so a new request is not accepted before the last one is through.
// after reset a clearing pass writes every entry invalid, during which
// o_ready stays low; apb writes are taken at any time.
// a stalled result holds in the output registers and no new request is
// taken until it is delivered.
// ----------------------------------------------------------------------------
`include "flow_state_table_macros.svh"

module flow_state_table #(
    parameter int TABLE_ENTRIES = fst_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_KEY_WORDS = fst_pkg::MAX_KEY_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [63:0] i_key_low,
    input  logic [63:0] i_key_high,
    input  logic [2:0]  i_key_words,
    input  logic [31:0] i_new_state,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_state_value,
    output logic        o_hit,
    output logic        o_status
);

    localparam int AW = $clog2(TABLE_ENTRIES);

    logic [31:0]       r_default_state;
    fst_pkg::t_ctl_cmd ctl_cmd;
    logic [AW-1:0]     addr, cmp_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_state <= '0;
        end else if (psel && penable && pwrite && pready &&
                     paddr == fst_pkg::REG_DEFAULT_STATE) begin
            r_default_state <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == fst_pkg::REG_DEFAULT_STATE) ? r_default_state : '0;

    fst_ctrl #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_ready   (i_ready),
        .o_ready   (o_ready),
        .o_valid   (o_valid),
        .o_cmd     (ctl_cmd),
        .o_addr    (addr),
        .o_cmp_addr(cmp_addr)
    );

    fst_datapath #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .MAX_KEY_WORDS(MAX_KEY_WORDS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (ctl_cmd),
        .i_addr         (addr),
        .i_cmp_addr     (cmp_addr),
        .i_default_state(r_default_state),
        .i_command      (i_command),
        .i_key_low      (i_key_low),
        .i_key_high     (i_key_high),
        .i_key_words    (i_key_words),
        .i_new_state    (i_new_state),
        .o_state_value  (o_state_value),
        .o_hit          (o_hit),
        .o_status       (o_status)
    );

    `FST_ASSERT_NOW(a_one_at_a_time, o_ready, !o_valid, "ready while result pending")
    `FST_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready && !o_valid,
        "request not held busy after accept")
    `FST_ASSERT_NEXT(a_idle_after_result, o_valid && i_ready, o_ready && !o_valid,
        "not idle after result delivered")

endmodule
